// File: design/dsd_pkg.sv
`default_nettype none

package dsd_pkg;

  // Field widths fixed by the symbol stream format.
  localparam int RESID_W  = 2;
  localparam int DCODE_W  = 4;
  localparam int INDEX_W  = 12;
  localparam int SAMPLE_W = 16;

  // Packed beat widths: slave tdata carries 34 bits of fields, padded to 40.
  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 16;

  // Residual code that escapes to a dictionary literal.
  localparam logic [RESID_W-1:0] ESCAPE_CODE = 2'd3;

  // A delta code step is 64, a left shift by six.
  localparam int DELTA_SHIFT = 6;

  // Stored values carry an offset of 32768 against the signed sample.
  localparam logic [SAMPLE_W-1:0] SAMPLE_OFFSET = 16'h8000;

  // Kind of an input beat.
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  // Control that travels with an item from the table read to reconstruction.
  typedef struct packed {
    logic                dec;
    logic                literal;
    logic                in_range;
    logic [RESID_W-1:0]  resid;
    logic [DCODE_W-1:0]  dcode;
  } dsd_ctl_t;

endpackage

`default_nettype wire

// File: design/delta_escape_sample_decoder.sv
// A decode beat is registered with its dictionary read, then in the output register.
// Throughput: one beat per cycle unless the output stalls. The dictionary RAM has one write
// and one read port; a load writes at its accept edge, so the next read sees the new value.
// Reset zeroes the previous stored value and empties the pipeline and output register.
// The dictionary is not cleared by reset; entries must be loaded before they are read.
`default_nettype none

module delta_escape_sample_decoder
  import dsd_pkg::*;
#(
  parameter int TABLE_DEPTH     = 4096,
  parameter int DELTA_CODE_BITS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // residual_code, delta_code, table_index, table_value, zero padding
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  // operation, first_sample
  input  wire logic [S_TUSER_W-1:0] s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // sample
  output logic [M_TDATA_W-1:0]      m_tdata,
  // from_literal
  output logic                      m_tuser
);

  localparam int AW = $clog2(TABLE_DEPTH);

  op_t                 operation;
  logic                first_sample;
  logic [RESID_W-1:0]  residual_code;
  logic [DCODE_W-1:0]  delta_code;
  logic [INDEX_W-1:0]  table_index;
  logic [SAMPLE_W-1:0] table_value;
  logic                accept;
  logic                in_range;
  logic [AW-1:0]       addr;
  dsd_ctl_t            ctl;
  logic [SAMPLE_W-1:0] rd_data;

  // Unpack the slave beat.
  assign operation     = op_t'(s_tuser[0]);
  assign first_sample  = s_tuser[1];
  assign residual_code = s_tdata[1:0];
  assign delta_code    = s_tdata[5:2];
  assign table_index   = s_tdata[17:6];
  assign table_value   = s_tdata[33:18];

  assign accept   = s_tvalid && s_tready;
  assign in_range = 32'(table_index) < TABLE_DEPTH;
  assign addr     = AW'(table_index);

  // Control carried alongside the table read.
  always_comb begin
    ctl.dec      = (operation == OP_DECODE);
    ctl.literal  = first_sample || (residual_code == ESCAPE_CODE);
    ctl.in_range = in_range;
    ctl.resid    = residual_code;
    ctl.dcode    = delta_code;
  end

  dsd_table_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (accept && (operation == OP_LOAD) && in_range),
    .waddr (addr),
    .wdata (table_value),
    .re    (accept),
    .raddr (addr),
    .rdata (rd_data)
  );

  dsd_recon #(
    .DELTA_CODE_BITS (DELTA_CODE_BITS)
  ) u_recon (
    .clk         (clk),
    .rst         (rst),
    .in_accept   (accept),
    .in_ctl      (ctl),
    .in_ready    (s_tready),
    .rd_data     (rd_data),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_sample  (m_tdata),
    .out_literal (m_tuser)
  );

endmodule

`default_nettype wire

// File: design/dsd_table_ram.sv
`default_nettype none

module dsd_table_ram
  import dsd_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       waddr,
  input  wire logic [SAMPLE_W-1:0] wdata,
  input  wire logic                re,
  input  wire logic [AW-1:0]       raddr,
  output logic      [SAMPLE_W-1:0] rdata
);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while no read is enabled.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/dsd_recon.sv
`default_nettype none

module dsd_recon
  import dsd_pkg::*;
#(
  parameter int DELTA_CODE_BITS = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // Item entering the reconstruction stage.
  input  wire logic                in_accept,
  input  wire dsd_ctl_t            in_ctl,
  output logic                     in_ready,
  // Dictionary read data for the item in this stage.
  input  wire logic [SAMPLE_W-1:0] rd_data,
  // Output register.
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [SAMPLE_W-1:0]      out_sample,
  output logic                     out_literal
);

  localparam logic [7:0] DCODE_MASK = 8'((1 << DELTA_CODE_BITS) - 1);
  // Bias times step, plus one for the residual code offset.
  localparam logic [SAMPLE_W-1:0] DELTA_OFFSET =
    SAMPLE_W'(((1 << (DELTA_CODE_BITS - 1)) << DELTA_SHIFT) + 1);

  logic                v1;
  dsd_ctl_t            ctl1;
  logic [SAMPLE_W-1:0] prev_value;
  logic [SAMPLE_W-1:0] value;
  logic [SAMPLE_W-1:0] delta;
  logic [7:0]          dcode_m;
  logic                out_free;
  logic                adv1;
  logic                emit;

  // The stage moves on when its item has no result or the output register is free.
  assign out_free = !out_valid || out_ready;
  assign adv1     = !ctl1.dec || out_free;
  assign in_ready = !v1 || adv1;
  assign emit     = v1 && ctl1.dec && out_free;

  // Stage valid and item control.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ctl1 <= in_ctl;
    end
  end

  // Delta path: previous value plus scaled code plus residual minus the offset, modulo 2^16.
  always_comb begin
    dcode_m = 8'(ctl1.dcode) & DCODE_MASK;
    delta   = (SAMPLE_W'(dcode_m) << DELTA_SHIFT) + SAMPLE_W'(ctl1.resid) - DELTA_OFFSET;
    if (ctl1.literal) begin
      value = ctl1.in_range ? rd_data : '0;
    end else begin
      value = prev_value + delta;
    end
  end

  // Previous stored value follows each emitted sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_value <= '0;
    end else if (emit) begin
      prev_value <= value;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sample  <= value - SAMPLE_OFFSET;
      out_literal <= ctl1.literal;
    end
  end

  // A result beat only starts from a decode item in this stage.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(v1 && ctl1.dec))
    else $error("output valid rose without a decode item");

  // A stalled item keeps its control.
  assert property (@(posedge clk) disable iff (rst)
    (v1 && !adv1) |=> (v1 && $stable(ctl1)))
    else $error("stalled item changed");

  // The literal flag of an emitted item reaches the output register.
  assert property (@(posedge clk) disable iff (rst)
    emit |=> (out_valid && (out_literal == $past(ctl1.literal))))
    else $error("emitted item lost or literal flag wrong");

  // The previous value changes only when a sample is emitted.
  assert property (@(posedge clk) disable iff (rst)
    !emit |=> $stable(prev_value))
    else $error("previous value changed without a sample");

endmodule

`default_nettype wire

// File: sim/delta_escape_sample_decoder_tb.sv
`timescale 1ns / 100ps

module delta_escape_sample_decoder_tb;
  import dsd_pkg::*;

  localparam int DEPTH          = 1 << INDEX_W;
  localparam int WATCHDOG_LIMIT = 4000;
  // Coarse delta bias in stored units: 2^(DCODE_W-1) steps of 64.
  localparam logic [SAMPLE_W-1:0] DELTA_BIAS = 16'((1 << (DCODE_W - 1)) << DELTA_SHIFT);

  typedef struct {
    op_t                 op;
    logic                first;
    logic [RESID_W-1:0]  resid;
    logic [DCODE_W-1:0]  dcode;
    logic [INDEX_W-1:0]  index;
    logic [SAMPLE_W-1:0] value;
  } symbol_t;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                literal;
  } sample_t;

  typedef enum {RX_ALWAYS, RX_LIGHT, RX_HEAVY} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;

  // Shadow of the decoder state.
  logic [SAMPLE_W-1:0] dict_shadow [DEPTH];
  bit                  dict_written [DEPTH];
  logic [INDEX_W-1:0]  written_indexes [$];
  logic [SAMPLE_W-1:0] prev_stored = '0;

  sample_t  pending_samples [$];
  sample_t  oldest_sample;
  int       err_count = 0;
  int       load_count = 0;
  int       literal_count = 0;
  int       delta_count = 0;
  int       checked_count = 0;
  int       stall_cycles = 0;
  int       burst_left = 0;
  int       rx_left = 0;
  bit       sender_bursty = 1'b0;
  rx_mode_t rx_mode = RX_ALWAYS;

  delta_escape_sample_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Work out the sample that a decode beat must produce and advance the shadow state.
  function automatic sample_t decode_symbol(input symbol_t s);
    sample_t r;
    if (s.first || s.resid == ESCAPE_CODE) begin
      prev_stored = dict_shadow[s.index];
      r.literal = 1'b1;
    end else begin
      prev_stored = prev_stored + (16'(s.dcode) << DELTA_SHIFT) + 16'(s.resid)
                    - DELTA_BIAS - 16'd1;
      r.literal = 1'b0;
    end
    r.sample = prev_stored - SAMPLE_OFFSET;
    return r;
  endfunction

  function automatic symbol_t make_symbol(input op_t op, input logic first,
                                          input logic [RESID_W-1:0] resid,
                                          input logic [DCODE_W-1:0] dcode,
                                          input logic [INDEX_W-1:0] index,
                                          input logic [SAMPLE_W-1:0] value);
    symbol_t s;
    s.op = op;
    s.first = first;
    s.resid = resid;
    s.dcode = dcode;
    s.index = index;
    s.value = value;
    return s;
  endfunction

  function automatic logic [INDEX_W-1:0] pick_written();
    return written_indexes[$urandom_range(0, written_indexes.size() - 1)];
  endfunction

  // Load with random don't-care fields anywhere in the table.
  function automatic symbol_t random_load();
    return make_symbol(OP_LOAD, 1'($urandom), 2'($urandom), 4'($urandom),
                       12'($urandom), 16'($urandom));
  endfunction

  // Delta decode; table fields are ignored, so they carry noise.
  function automatic symbol_t random_delta();
    return make_symbol(OP_DECODE, 1'b0, 2'($urandom_range(0, 2)), 4'($urandom),
                       12'($urandom), 16'($urandom));
  endfunction

  // Literal decode, either a stream start or an escape, from a loaded entry.
  function automatic symbol_t random_literal(input logic first);
    return make_symbol(OP_DECODE, first, first ? 2'($urandom) : ESCAPE_CODE,
                       4'($urandom), pick_written(), 16'($urandom));
  endfunction

  // Present one beat, wait for the handshake, then update the shadow state.
  task automatic send_symbol(input symbol_t s);
    if (sender_bursty && burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    // Padding above table_value stays zero.
    s_tdata  <= {{(S_TDATA_W - 34){1'b0}}, s.value, s.index, s.dcode, s.resid};
    s_tuser  <= {s.first, s.op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (s.op == OP_LOAD) begin
      dict_shadow[s.index] = s.value;
      if (!dict_written[s.index]) begin
        dict_written[s.index] = 1'b1;
        written_indexes.push_back(s.index);
      end
      load_count++;
    end else begin
      pending_samples.push_back(decode_symbol(s));
      if (pending_samples[$].literal) literal_count++;
      else delta_count++;
    end
  endtask

  // Hold the sender off until every outstanding sample has come back.
  task automatic drain_samples();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
    err_count++;
  endtask

  // Table extremes, ignored fields on loads, literal starts and escapes.
  task automatic test_table_literals();
    send_symbol(make_symbol(OP_LOAD, 1'b0, 2'd0, 4'd0, 12'h000, 16'h0000));
    send_symbol(make_symbol(OP_LOAD, 1'b1, ESCAPE_CODE, 4'hF, 12'hFFF, 16'hFFFF));
    send_symbol(make_symbol(OP_LOAD, 1'b0, 2'd1, 4'h8, 12'h800, 16'h8000));
    send_symbol(make_symbol(OP_LOAD, 1'b1, 2'd2, 4'h7, 12'h7FF, 16'h7FFF));
    send_symbol(make_symbol(OP_DECODE, 1'b1, 2'd0, 4'd0, 12'h000, 16'hFFFF));
    send_symbol(make_symbol(OP_DECODE, 1'b1, ESCAPE_CODE, 4'hF, 12'hFFF, 16'h0000));
    send_symbol(make_symbol(OP_DECODE, 1'b0, ESCAPE_CODE, 4'hF, 12'h800, 16'h1234));
    send_symbol(make_symbol(OP_DECODE, 1'b0, ESCAPE_CODE, 4'h0, 12'h7FF, 16'h0000));
  endtask

  // A literal read on the beat right after a load of the same entry.
  task automatic test_load_then_read();
    send_symbol(make_symbol(OP_LOAD, 1'b0, 2'd0, 4'd0, 12'h123, 16'h1234));
    send_symbol(make_symbol(OP_DECODE, 1'b1, 2'd1, 4'd3, 12'h123, 16'h0000));
    send_symbol(make_symbol(OP_LOAD, 1'b0, 2'd0, 4'd0, 12'h123, 16'hABCD));
    send_symbol(make_symbol(OP_DECODE, 1'b0, ESCAPE_CODE, 4'd3, 12'h123, 16'h0000));
  endtask

  // Largest and smallest deltas with wrap in both directions, and the neutral code.
  task automatic test_delta_extremes();
    send_symbol(make_symbol(OP_DECODE, 1'b0, ESCAPE_CODE, 4'd0, 12'hFFF, 16'h0000));
    send_symbol(make_symbol(OP_DECODE, 1'b0, 2'd2, 4'hF, 12'h000, 16'h0000));
    send_symbol(make_symbol(OP_DECODE, 1'b0, ESCAPE_CODE, 4'd0, 12'h000, 16'h0000));
    send_symbol(make_symbol(OP_DECODE, 1'b0, 2'd0, 4'h0, 12'hFFF, 16'hFFFF));
    send_symbol(make_symbol(OP_DECODE, 1'b0, 2'd1, 4'h8, 12'h000, 16'h0000));
    send_symbol(make_symbol(OP_DECODE, 1'b0, 2'd0, 4'h8, 12'h000, 16'h0000));
    send_symbol(make_symbol(OP_DECODE, 1'b0, 2'd2, 4'h8, 12'h000, 16'h0000));
    send_symbol(make_symbol(OP_DECODE, 1'b0, 2'd1, 4'h7, 12'hFFF, 16'hFFFF));
    send_symbol(make_symbol(OP_DECODE, 1'b0, 2'd1, 4'h9, 12'h555, 16'hAAAA));
  endtask

  // Mostly well-formed streams: a few loads, a literal start, then a run of deltas
  // with escapes, with some reloads, restarts and arbitrary beats mixed in.
  task automatic test_random_streams(input int beats, input bit bursty, input rx_mode_t rx);
    int      sent;
    int      run;
    int      roll;
    symbol_t s;
    sent = 0;
    sender_bursty = bursty;
    rx_mode = rx;
    while (sent < beats) begin
      repeat ($urandom_range(1, 3)) begin
        send_symbol(random_load());
        sent++;
      end
      send_symbol(random_literal(1'b1));
      sent++;
      run = $urandom_range(4, 24);
      repeat (run) begin
        roll = $urandom_range(0, 99);
        if (roll < 68) s = random_delta();
        else if (roll < 80) s = random_literal(1'b0);
        else if (roll < 88) s = random_load();
        else if (roll < 93) s = random_literal(1'b1);
        else begin
          s = make_symbol(op_t'($urandom_range(0, 1)), 1'($urandom), 2'($urandom),
                          4'($urandom), 12'($urandom), 16'($urandom));
          // Never read an entry that was never loaded.
          if (s.op == OP_DECODE && (s.first || s.resid == ESCAPE_CODE) &&
              !dict_written[s.index])
            s.index = pick_written();
        end
        send_symbol(s);
        sent++;
      end
    end
    drain_samples();
  endtask

  // Receiver: always ready, or ready runs alternating with stalls of mode-set length.
  always @(posedge clk) begin
    if (rx_mode == RX_ALWAYS) begin
      m_tready <= 1'b1;
    end else if (rx_left == 0) begin
      m_tready <= !m_tready;
      rx_left  <= m_tready ? $urandom_range(0, (rx_mode == RX_HEAVY) ? 20 : 3)
                           : $urandom_range(0, 8);
    end else begin
      rx_left <= rx_left - 1;
    end
  end

  // Compare each output beat with the oldest outstanding sample.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected sample beat", $signed(m_tdata), 0);
      end else begin
        oldest_sample = pending_samples.pop_front();
        checked_count++;
        if (m_tdata !== oldest_sample.sample)
          report_mismatch("sample", $signed(m_tdata), $signed(oldest_sample.sample));
        if (m_tuser !== oldest_sample.literal)
          report_mismatch("from_literal", m_tuser, oldest_sample.literal);
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d samples outstanding", pending_samples.size());
      $display("[delta_escape_sample_decoder] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_table_literals();
    test_load_then_read();
    test_delta_extremes();
    drain_samples();
    test_random_streams(250, 1'b0, RX_ALWAYS);
    test_random_streams(250, 1'b1, RX_LIGHT);
    test_random_streams(230, 1'b1, RX_HEAVY);

    drain_samples();
    repeat (8) @(posedge clk);
    $display("Sent %0d table loads, %0d literal and %0d delta decodes.",
             load_count, literal_count, delta_count);
    $display("Checked %0d sample beats with %0d table entries loaded.",
             checked_count, written_indexes.size());
    if (err_count == 0) begin
      $display("[delta_escape_sample_decoder] OK");
    end else begin
      $display("[delta_escape_sample_decoder] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
design/dsd_pkg.sv
design/dsd_table_ram.sv
design/dsd_recon.sv
design/delta_escape_sample_decoder.sv
sim/delta_escape_sample_decoder_tb.sv
